>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define UVS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UVS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Constants, types and arithmetic helpers of the UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int STACK_MAX  = 256;
  localparam int SLICE_MAX  = 256;
  localparam int CNT_W      = 9;
  localparam int DVD_W      = 25;
  localparam int QUO_W      = 17;
  localparam int REM_W      = 8;
  localparam int DIV_STEPS  = QUO_W;
  localparam int SIN_STAGES = 4;

  // pipeline stage map
  localparam int ST_DIV0 = 1;
  localparam int ST_SIN0 = ST_DIV0 + DIV_STEPS;
  localparam int ST_NRM  = ST_SIN0 + SIN_STAGES;
  localparam int ST_OUT  = ST_NRM + 1;
  localparam int N_STG   = ST_OUT + 1;

  // register indexes
  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_STACKS = 2'd1,
    REG_SLICES = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [16:0] vidx;
    logic        qv;
  } meta_t;

  function automatic logic [15:0] abs16(input logic signed [15:0] a);
    return a[15] ? 16'(-a) : 16'(a);
  endfunction

  // magnitude product rounded half away from zero, shifted by 14
  function automatic logic signed [17:0] mul_r14(input logic signed [15:0] a,
                                                 input logic [15:0] bm,
                                                 input logic bn);
    logic [31:0] p;
    logic [17:0] r;
    p = 32'(abs16(a)) * 32'(bm);
    r = 18'((p + 32'd8192) >> 14);
    return (a[15] ^ bn) ? -$signed(r) : $signed(r);
  endfunction

endpackage

>>> rtl/core/uvs_ifs.sv
// ----------------------------------------------------------------------------
// uvs_ifs
// Grid point request channel and vertex result channel.
// ----------------------------------------------------------------------------
interface uvs_in_if;
  import uvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] stack_idx;
  logic [CNT_W-1:0] slice_idx;
  modport source (output valid, stack_idx, slice_idx, input ready);
  modport sink   (input valid, stack_idx, slice_idx, output ready);
endinterface

interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [16:0] pos_z;
  logic signed [15:0] nrm_x;
  logic signed [15:0] nrm_y;
  logic signed [15:0] nrm_z;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic signed [15:0] tan_x;
  logic signed [15:0] tan_z;
  logic [16:0]        vertex_index;
  logic               quad_valid;
  modport source (output valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v,
                  tan_x, tan_z, vertex_index, quad_valid, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v,
                  tan_x, tan_z, vertex_index, quad_valid, output ready);
endinterface

>>> rtl/core/uvs_div.sv
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module uvs_div (
  input  logic                           clk,
  input  logic [uvs_pkg::DIV_STEPS-1:0]  ld,
  input  logic [uvs_pkg::DVD_W-1:0]      dividend,
  input  logic [uvs_pkg::CNT_W-1:0]      divisor,
  output logic [uvs_pkg::QUO_W-1:0]      quo
);
  import uvs_pkg::*;

  logic [REM_W-1:0] rem_r  [DIV_STEPS];
  logic [QUO_W-1:0] rq_r   [DIV_STEPS];
  logic [REM_W-1:0] rem_in [DIV_STEPS];
  logic [QUO_W-1:0] rq_in  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [CNT_W-1:0] cand;
    logic             ge;
    if (k == 0) begin : g_first
      assign rem_in[k] = dividend[DVD_W-1:QUO_W];
      assign rq_in[k]  = dividend[QUO_W-1:0];
    end else begin : g_rest
      assign rem_in[k] = rem_r[k-1];
      assign rq_in[k]  = rq_r[k-1];
    end
    assign cand = {rem_in[k], rq_in[k][QUO_W-1]};
    assign ge   = (cand >= divisor);
    always_ff @(posedge clk) begin
      if (ld[k]) begin
        rem_r[k] <= ge ? REM_W'(cand - divisor) : cand[REM_W-1:0];
        rq_r[k]  <= {rq_in[k][QUO_W-2:0], ge};
      end
    end
  end

  assign quo = rq_r[DIV_STEPS-1];

endmodule

>>> rtl/core/uvs_sine.sv
// ----------------------------------------------------------------------------
// uvs_sine
// Four-stage polynomial sine of a Q0.16 phase, result in Q1.14.
// ----------------------------------------------------------------------------
module uvs_sine (
  input  logic                           clk,
  input  logic [uvs_pkg::SIN_STAGES-1:0] ld,
  input  logic [15:0]                    phase,
  output logic signed [15:0]             sin_o
);
  import uvs_pkg::*;

  logic [15:0] a_t_r, b_t_r, c_t_r;
  logic [1:0]  a_q_r, b_q_r, c_q_r;
  logic [15:0] a_t2_r, b_t2_r;
  logic [14:0] b_i_r;
  logic [15:0] c_m_r;
  logic signed [15:0] d_s_r;

  logic [14:0] t_base;
  logic [15:0] t_a;
  logic [31:0] p_a, p_c, p_d;
  logic [26:0] p_b;
  logic [16:0] s_d;
  logic [14:0] r_d;

  always_comb begin
    t_base = {phase[13:0], 1'b0};
    t_a    = phase[14] ? 16'(16'd32768 - 16'(t_base)) : 16'(t_base);
    p_a    = 32'(t_a) * 32'(t_a);
    p_b    = 27'(a_t2_r) * 27'd2320;
    p_c    = 32'(b_t2_r) * 32'(b_i_r);
    p_d    = 32'(c_t_r) * 32'(c_m_r);
    s_d    = p_d[31:15];
    r_d    = 15'((s_d + 17'd1) >> 1);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      a_t_r  <= t_a;
      a_q_r  <= phase[15:14];
      a_t2_r <= p_a[30:15];
    end
    if (ld[1]) begin
      b_t_r  <= a_t_r;
      b_q_r  <= a_q_r;
      b_t2_r <= a_t2_r;
      b_i_r  <= 15'(15'd21024 - 15'(p_b[26:15]));
    end
    if (ld[2]) begin
      c_t_r <= b_t_r;
      c_q_r <= b_q_r;
      c_m_r <= 16'(16'd51472 - p_c[30:15]);
    end
    if (ld[3]) begin
      d_s_r <= c_q_r[1] ? -$signed({1'b0, r_d}) : $signed({1'b0, r_d});
    end
  end

  assign sin_o = d_s_r;

endmodule

>>> rtl/core/uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Position, normal, texture coordinates, tangent and index of a UV sphere
// grid point.
// ----------------------------------------------------------------------------
//  channel | direction | handshake       | payload
//  in_if   | sink      | valid / ready   | stack_idx, slice_idx
//  out_if  | source    | valid / ready   | pos, nrm, tex, tan, vertex_index,
//          |           |                 | quad_valid
//  cfg     | APB slave | psel/penable    | radius, stack and slice counts
//
// One request per cycle sustained while the output is ready; the pipeline depth is set by the
// 17-step bit-per-stage dividers and the four-multiply sine pipeline.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: radius 1.0, 16 stacks, 32 slices.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled output holds its data and bubbles upstream still collapse.
`include "assert_macros.svh"

module uv_sphere_vertex_generator (
  input  logic        clk,
  input  logic        rst_n,
  uvs_in_if.sink      in_if,
  uvs_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import uvs_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0]      radius_r;
  logic [CNT_W-1:0] stacks_r, slices_r;
  reg_idx_t         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd256;
      stacks_r <= CNT_W'(16);
      slices_r <= CNT_W'(32);
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_RADIUS: radius_r <= pwdata[15:0];
        REG_STACKS: stacks_r <= pwdata[CNT_W-1:0];
        REG_SLICES: slices_r <= pwdata[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIUS: prdata = {16'd0, radius_r};
      REG_STACKS: prdata = {23'd0, stacks_r};
      REG_SLICES: prdata = {23'd0, slices_r};
      default:    prdata = 32'd0;
    endcase
  end

  // clamp the counts to their legal ranges
  logic [CNT_W-1:0] stacks_c, slices_c;
  always_comb begin
    if (stacks_r < CNT_W'(2))              stacks_c = CNT_W'(2);
    else if (stacks_r > CNT_W'(STACK_MAX)) stacks_c = CNT_W'(STACK_MAX);
    else                                   stacks_c = stacks_r;
    if (slices_r < CNT_W'(3))              slices_c = CNT_W'(3);
    else if (slices_r > CNT_W'(SLICE_MAX)) slices_c = CNT_W'(SLICE_MAX);
    else                                   slices_c = slices_r;
  end

  // --------------------------------------------------------------------------
  // Stage valid bits and load chain
  // --------------------------------------------------------------------------
  logic [N_STG-1:0] vld_r, ld;

  assign ld[N_STG-1] = !vld_r[N_STG-1] || out_if.ready;
  for (genvar k = 0; k < N_STG - 1; k++) begin : g_ld
    assign ld[k] = !vld_r[k] || ld[k+1];
  end
  assign in_if.ready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) vld_r[0] <= in_if.valid;
      for (int k = 1; k < N_STG; k++) begin
        if (ld[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: saturate indices, form dividends, flat index and quad flag
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] st, sl;
  logic [18:0]      vidx_full;
  logic [DVD_W-1:0] dvd_u_r, dvd_v_r, dvd_p_r;
  meta_t            meta_r [N_STG];

  always_comb begin
    st        = (in_if.stack_idx > stacks_c) ? stacks_c : in_if.stack_idx;
    sl        = (in_if.slice_idx > slices_c) ? slices_c : in_if.slice_idx;
    vidx_full = 19'(19'(st) * 19'({1'b0, slices_c} + 10'd1)) + 19'(sl);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      dvd_u_r        <= DVD_W'({sl, 16'd0}) + DVD_W'(slices_c >> 1);
      dvd_v_r        <= DVD_W'({st, 16'd0}) + DVD_W'(stacks_c >> 1);
      dvd_p_r        <= DVD_W'({st, 15'd0}) + DVD_W'(stacks_c >> 1);
      meta_r[0].vidx <= vidx_full[16:0];
      meta_r[0].qv   <= (st < stacks_c) && (sl < slices_c);
    end
  end

  // carry index and flag alongside the arithmetic
  for (genvar k = 1; k < N_STG; k++) begin : g_meta
    always_ff @(posedge clk) begin
      if (ld[k]) meta_r[k] <= meta_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1..17: u, v and polar phase dividers
  // --------------------------------------------------------------------------
  logic [QUO_W-1:0] u_q, v_q, p_q;

  uvs_div u_div_u (.clk, .ld(ld[ST_SIN0-1:ST_DIV0]), .dividend(dvd_u_r),
                   .divisor(slices_c), .quo(u_q));
  uvs_div u_div_v (.clk, .ld(ld[ST_SIN0-1:ST_DIV0]), .dividend(dvd_v_r),
                   .divisor(stacks_c), .quo(v_q));
  uvs_div u_div_p (.clk, .ld(ld[ST_SIN0-1:ST_DIV0]), .dividend(dvd_p_r),
                   .divisor(stacks_c), .quo(p_q));

  // --------------------------------------------------------------------------
  // Stages 18..21: sine and cosine of both angles
  // --------------------------------------------------------------------------
  logic signed [15:0] sp, cp, stt, ctt;
  logic [QUO_W-1:0]   u_r [SIN_STAGES];
  logic [QUO_W-1:0]   v_r [SIN_STAGES];

  uvs_sine u_sin_p (.clk, .ld(ld[ST_NRM-1:ST_SIN0]), .phase(p_q[15:0]), .sin_o(sp));
  uvs_sine u_cos_p (.clk, .ld(ld[ST_NRM-1:ST_SIN0]),
                    .phase(16'(p_q[15:0] + 16'd16384)), .sin_o(cp));
  uvs_sine u_sin_t (.clk, .ld(ld[ST_NRM-1:ST_SIN0]), .phase(u_q[15:0]), .sin_o(stt));
  uvs_sine u_cos_t (.clk, .ld(ld[ST_NRM-1:ST_SIN0]),
                    .phase(16'(u_q[15:0] + 16'd16384)), .sin_o(ctt));

  for (genvar j = 0; j < SIN_STAGES; j++) begin : g_uv
    always_ff @(posedge clk) begin
      if (ld[ST_SIN0+j]) begin
        u_r[j] <= (j == 0) ? u_q : u_r[(j == 0) ? 0 : j-1];
        v_r[j] <= (j == 0) ? v_q : v_r[(j == 0) ? 0 : j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 22: normal
  // --------------------------------------------------------------------------
  logic signed [15:0] nx_r, ny_r, nz_r, ctt_r, stt_r;
  logic [QUO_W-1:0]   u2_r, v2_r;
  logic signed [17:0] nx_full, nz_full;

  assign nx_full = mul_r14(stt, abs16(sp), sp[15]);
  assign nz_full = mul_r14(ctt, abs16(sp), sp[15]);

  always_ff @(posedge clk) begin
    if (ld[ST_NRM]) begin
      nx_r  <= nx_full[15:0];
      ny_r  <= cp;
      nz_r  <= nz_full[15:0];
      ctt_r <= ctt;
      stt_r <= stt;
      u2_r  <= u_r[SIN_STAGES-1];
      v2_r  <= v_r[SIN_STAGES-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 23: scale by radius into the output register
  // --------------------------------------------------------------------------
  logic signed [17:0] px_full, py_full, pz_full;
  assign px_full = mul_r14(nx_r, radius_r, 1'b0);
  assign py_full = mul_r14(ny_r, radius_r, 1'b0);
  assign pz_full = mul_r14(nz_r, radius_r, 1'b0);

  logic signed [16:0] pos_x_r, pos_y_r, pos_z_r;
  logic signed [15:0] nrm_x_r, nrm_y_r, nrm_z_r, tan_x_r, tan_z_r;
  logic [16:0]        tex_u_r, tex_v_r;

  always_ff @(posedge clk) begin
    if (ld[ST_OUT]) begin
      pos_x_r <= px_full[16:0];
      pos_y_r <= py_full[16:0];
      pos_z_r <= pz_full[16:0];
      nrm_x_r <= nx_r;
      nrm_y_r <= ny_r;
      nrm_z_r <= nz_r;
      tex_u_r <= u2_r;
      tex_v_r <= v2_r;
      tan_x_r <= ctt_r;
      tan_z_r <= 16'(-stt_r);
    end
  end

  assign out_if.valid        = vld_r[ST_OUT];
  assign out_if.pos_x        = pos_x_r;
  assign out_if.pos_y        = pos_y_r;
  assign out_if.pos_z        = pos_z_r;
  assign out_if.nrm_x        = nrm_x_r;
  assign out_if.nrm_y        = nrm_y_r;
  assign out_if.nrm_z        = nrm_z_r;
  assign out_if.tex_u        = tex_u_r;
  assign out_if.tex_v        = tex_v_r;
  assign out_if.tan_x        = tan_x_r;
  assign out_if.tan_z        = tan_z_r;
  assign out_if.vertex_index = meta_r[ST_OUT].vidx;
  assign out_if.quad_valid   = meta_r[ST_OUT].qv;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `UVS_ASSERT_IMP(a_full_blocks, (&vld_r) && !out_if.ready, !in_if.ready,
                  "full pipeline accepted a request under output stall")
  `UVS_ASSERT_NXT(a_out_holds, vld_r[ST_OUT] && !out_if.ready, vld_r[ST_OUT],
                  "stalled result dropped")
  `UVS_ASSERT_IMP(a_quad_tex, vld_r[ST_OUT] && meta_r[ST_OUT].qv,
                  tex_u_r < 17'd65536 && tex_v_r < 17'd65536,
                  "quad start vertex on the seam row or column")
  `UVS_ASSERT_IMP(a_nrm_range, vld_r[ST_OUT],
                  nrm_y_r <= 16'sd16384 && nrm_y_r >= -16'sd16384,
                  "normal y out of unit range")

endmodule
